FILE: hw/rtl/vhws_pkg.sv
package vhws_pkg;

    // Default geometry
    localparam int unsigned CHUNK_SIDE_DEF     = 16;
    localparam int unsigned WORLD_CHUNKS_X_DEF = 4;
    localparam int unsigned WORLD_CHUNKS_Y_DEF = 4;
    localparam int unsigned WORLD_CHUNKS_Z_DEF = 4;

    // Field widths
    localparam int COORD_W = 8;
    localparam int VALUE_W = 8;
    localparam int ADDR_W  = 19;

    // Shared multiply-add unit: modular arithmetic on UNIT_W bits
    localparam int UNIT_W      = 21;
    // Reciprocal scale for the divide by the chunk side
    localparam int RECIP_SHIFT = 14;
    // Width of the coordinate bound compare (up to 16 chunks of 64 cells)
    localparam int BOUND_W     = 11;
    // Chunk index width (coordinate magnitude)
    localparam int CHUNK_W     = 7;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [VALUE_W-1:0]        block_value;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  write_address;
        logic [VALUE_W-1:0] write_value;
        logic               last_write;
    } wr_t;

endpackage

FILE: hw/rtl/voxel_halo_write_scatter_top.sv
// Once a coordinate is accepted, the sequencer makes 15 passes through the shared
// multiply-add unit, five per axis; then n = 1..8 writes follow, one per cycle when
// wr_ready is high. No new coordinate is taken before the last write.
// An out-of-range coordinate is dropped in its accept cycle; the block stays ready.
// Reset (rst_n low, asynchronous) returns the sequencer to idle with no write pending.
module voxel_halo_write_scatter_top #(
    parameter int unsigned CHUNK_SIDE     = vhws_pkg::CHUNK_SIDE_DEF,
    parameter int unsigned WORLD_CHUNKS_X = vhws_pkg::WORLD_CHUNKS_X_DEF,
    parameter int unsigned WORLD_CHUNKS_Y = vhws_pkg::WORLD_CHUNKS_Y_DEF,
    parameter int unsigned WORLD_CHUNKS_Z = vhws_pkg::WORLD_CHUNKS_Z_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  vhws_pkg::cmd_t cmd,
    output logic           wr_valid,
    input  logic           wr_ready,
    output vhws_pkg::wr_t  wr
);

    localparam int UW  = vhws_pkg::UNIT_W;
    localparam int BW  = vhws_pkg::BOUND_W;
    localparam int QW  = vhws_pkg::CHUNK_W;
    localparam int AW  = vhws_pkg::ADDR_W;
    localparam int RS  = vhws_pkg::RECIP_SHIFT;
    localparam int LW  = (CHUNK_SIDE > 1) ? $clog2(CHUNK_SIDE) : 1;
    localparam int PAD = CHUNK_SIDE + 2;

    localparam int LIM_X = WORLD_CHUNKS_X * CHUNK_SIDE;
    localparam int LIM_Y = WORLD_CHUNKS_Y * CHUNK_SIDE;
    localparam int LIM_Z = WORLD_CHUNKS_Z * CHUNK_SIDE;

    localparam int RECIP = ((1 << RS) + CHUNK_SIDE - 1) / CHUNK_SIDE;
    localparam int NEG_C = (1 << UW) - CHUNK_SIDE;

    // Address weights of local offset and chunk index per axis
    localparam int LK_X = 1;
    localparam int LK_Y = PAD;
    localparam int LK_Z = PAD * PAD;
    localparam int CK_X = PAD * PAD * PAD;
    localparam int CK_Y = CK_X * WORLD_CHUNKS_X;
    localparam int CK_Z = CK_Y * WORLD_CHUNKS_Y;

    // Address deltas to the neighbor halo cell: low face (+C cells, -1 chunk)
    localparam int DLO_X = CHUNK_SIDE * LK_X - CK_X;
    localparam int DLO_Y = CHUNK_SIDE * LK_Y - CK_Y;
    localparam int DLO_Z = CHUNK_SIDE * LK_Z - CK_Z;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_QUO  = 7'b0000010,
        S_REM  = 7'b0000100,
        S_LOC  = 7'b0001000,
        S_CHK  = 7'b0010000,
        S_ALT  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           axis_reg, axis_next;
    logic [7:0]           mask_reg, mask_next;
    logic [2:0]           alt_ok_reg;
    logic [QW-1:0]        p_reg [3];
    logic [vhws_pkg::VALUE_W-1:0] value_reg;
    logic [UW-1:0]        acc_reg;
    logic [QW-1:0]        q_reg;
    logic [LW-1:0]        l_reg;
    logic [UW-1:0]        t_main_reg [3];
    logic [UW-1:0]        t_alt_reg [3];

    logic                 in_range;
    logic                 cmd_fire, wr_fire;
    logic [UW-1:0]        op_add, op_a, op_b, unit_res;
    logic [QW-1:0]        p_cur;
    logic [UW-1:0]        lk_cur, ck_cur, dlo_cur;
    logic [QW-1:0]        qmax_cur;
    logic                 face_lo, face_hi, alt_now;
    logic [2:0]           ok_all;
    logic [7:0]           mask_init;
    logic [2:0]           cur;
    logic [7:0]           cur_bit;
    logic [UW-1:0]        addr_sum;

    assign cmd_ready = (state_reg == S_IDLE);
    assign wr_valid  = (state_reg == S_EMIT);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign wr_fire   = wr_valid && wr_ready;

    // Check the coordinate against the world bounds
    assign in_range = !cmd.pos_x[7] && !cmd.pos_y[7] && !cmd.pos_z[7]
        && (BW'(cmd.pos_x[6:0]) < BW'(LIM_X))
        && (BW'(cmd.pos_y[6:0]) < BW'(LIM_Y))
        && (BW'(cmd.pos_z[6:0]) < BW'(LIM_Z));

    // Select per-axis constants
    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                lk_cur   = UW'(LK_X);
                ck_cur   = UW'(CK_X);
                dlo_cur  = UW'(DLO_X);
                qmax_cur = QW'(WORLD_CHUNKS_X - 1);
            end
            AXIS_Y:
            begin
                lk_cur   = UW'(LK_Y);
                ck_cur   = UW'(CK_Y);
                dlo_cur  = UW'(DLO_Y);
                qmax_cur = QW'(WORLD_CHUNKS_Y - 1);
            end
            default:
            begin
                lk_cur   = UW'(LK_Z);
                ck_cur   = UW'(CK_Z);
                dlo_cur  = UW'(DLO_Z);
                qmax_cur = QW'(WORLD_CHUNKS_Z - 1);
            end
        endcase
    end

    assign p_cur = (axis_reg == AXIS_X) ? p_reg[0] :
                   (axis_reg == AXIS_Y) ? p_reg[1] : p_reg[2];

    // Face detection and neighbor-in-grid check for the current axis
    assign face_lo = (l_reg == '0);
    assign face_hi = (l_reg == LW'(CHUNK_SIDE - 1));
    assign alt_now = face_lo ? (q_reg != '0) : (face_hi && (q_reg != qmax_cur));

    // Feed the shared multiply-add unit
    always_comb
    begin
        op_add = '0;
        op_a   = '0;
        op_b   = '0;
        unique case (state_reg)
            S_QUO:
            begin
                op_a = UW'(p_cur);
                op_b = UW'(RECIP);
            end
            S_REM:
            begin
                op_add = UW'(p_cur);
                op_a   = UW'(q_reg);
                op_b   = UW'(NEG_C);
            end
            S_LOC:
            begin
                op_add = lk_cur;
                op_a   = UW'(l_reg);
                op_b   = lk_cur;
            end
            S_CHK:
            begin
                op_add = acc_reg;
                op_a   = UW'(q_reg);
                op_b   = ck_cur;
            end
            S_ALT:
            begin
                op_add = acc_reg;
                op_a   = face_lo ? dlo_cur : (~dlo_cur + UW'(1));
                op_b   = UW'(1);
            end
            default:
            begin
                op_add = '0;
            end
        endcase
    end

    assign unit_res = UW'(op_add + UW'(op_a * op_b));

    // Build the combination mask: z alternative innermost, x outermost
    assign ok_all = {alt_now, alt_ok_reg[1:0]};
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            mask_init[c] = (!c[2] || ok_all[0]) && (!c[1] || ok_all[1])
                && (!c[0] || ok_all[2]);
        end
    end

    // Pick the lowest pending combination
    always_comb
    begin
        cur = '0;
        for (int c = 7; c >= 0; c--)
        begin
            if (mask_reg[c])
            begin
                cur = 3'(c);
            end
        end
        cur_bit = 8'b1 << cur;
    end

    assign addr_sum = UW'((cur[2] ? t_alt_reg[0] : t_main_reg[0])
        + (cur[1] ? t_alt_reg[1] : t_main_reg[1])
        + (cur[0] ? t_alt_reg[2] : t_main_reg[2]));

    assign wr.write_address = addr_sum[AW-1:0];
    assign wr.write_value   = value_reg;
    assign wr.last_write    = ((mask_reg & ~cur_bit) == '0);

    // Sequence the unit over the three axes, then emit
    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        mask_next  = mask_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire && in_range)
                begin
                    state_next = S_QUO;
                    axis_next  = AXIS_X;
                end
            end
            S_QUO:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                state_next = S_LOC;
            end
            S_LOC:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_ALT;
            end
            S_ALT:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = S_EMIT;
                    mask_next  = mask_init;
                end
                else
                begin
                    state_next = S_QUO;
                    axis_next  = axis_reg + 2'd1;
                end
            end
            S_EMIT:
            begin
                if (wr_fire)
                begin
                    mask_next = mask_reg & ~cur_bit;
                    if (wr.last_write)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= AXIS_X;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            mask_reg  <= mask_next;
        end
    end

    // Hold the datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            p_reg[0]  <= cmd.pos_x[6:0];
            p_reg[1]  <= cmd.pos_y[6:0];
            p_reg[2]  <= cmd.pos_z[6:0];
            value_reg <= cmd.block_value;
        end
        if (state_reg != S_IDLE && state_reg != S_EMIT)
        begin
            acc_reg <= unit_res;
        end
        if (state_reg == S_QUO)
        begin
            q_reg <= unit_res[RS +: QW];
        end
        if (state_reg == S_REM)
        begin
            l_reg <= unit_res[LW-1:0];
        end
        if (state_reg == S_ALT)
        begin
            unique case (axis_reg)
                AXIS_X:
                begin
                    t_main_reg[0] <= acc_reg;
                    t_alt_reg[0]  <= unit_res;
                    alt_ok_reg[0] <= alt_now;
                end
                AXIS_Y:
                begin
                    t_main_reg[1] <= acc_reg;
                    t_alt_reg[1]  <= unit_res;
                    alt_ok_reg[1] <= alt_now;
                end
                default:
                begin
                    t_main_reg[2] <= acc_reg;
                    t_alt_reg[2]  <= unit_res;
                    alt_ok_reg[2] <= alt_now;
                end
            endcase
        end
    end

    // Never take a coordinate while writes are pending
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ready && wr_valid))
        else $error("cmd_ready high while a write word is pending");

    // The final write returns the block to ready
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_ready && wr.last_write |=> cmd_ready)
        else $error("block not ready after final write");

    // A non-final write is followed by another write
    a_more_writes: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_ready && !wr.last_write |=> wr_valid)
        else $error("write sequence ended without last_write");

    // Emit phase always has a pending combination
    a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> mask_reg != '0)
        else $error("emit phase with empty combination mask");

endmodule
